FILE: design/svpwm_pkg.sv
package svpwm_pkg;

   // field widths
   localparam int AXIS_W    = 16;
   localparam int SECTOR_W  = 3;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int V2_W      = 17;
   localparam int VWIDE_W   = 19;
   localparam int TIME_W    = 18;
   localparam int PROD1_W   = TIME_W + CSR_W;
   localparam int PROD2_W   = PROD1_W + CSR_W;
   localparam int SHIFT     = 27;
   localparam int SCALED_W  = PROD2_W - SHIFT;
   localparam int SUM_W     = SCALED_W + 2;

   // sqrt(3)/2 in q15
   localparam logic signed [31:0] SQRT3_HALF_Q15 = 32'sd28378;

   // phase time saturation limits
   localparam logic signed [VWIDE_W-1:0] T_MAX = 19'sd131071;
   localparam logic signed [VWIDE_W-1:0] T_MIN = -19'sd131072;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELOAD = 2'd2;

   // register reset values
   localparam logic [CSR_W-1:0] GAIN_RESET   = 16'd4096;
   localparam logic [CSR_W-1:0] HALF_RESET   = 16'd4250;
   localparam logic [CSR_W-1:0] RELOAD_RESET = 16'd8500;

   typedef struct packed {
      logic signed [AXIS_W-1:0] u_alpha;
      logic signed [AXIS_W-1:0] u_beta;
   } req_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [CSR_W-1:0]    compare_a;
      logic [CSR_W-1:0]    compare_b;
      logic [CSR_W-1:0]    compare_c;
   } rsp_type;

endpackage

FILE: design/svpwm_req_if.sv
interface svpwm_req_if;
   import svpwm_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/svpwm_rsp_if.sv
interface svpwm_rsp_if;
   import svpwm_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/svpwm_scale.sv
module svpwm_scale (
   input  logic                           clock,
   input  logic [2:0]                     adv,
   input  logic                           t_neg,
   input  logic [svpwm_pkg::TIME_W-1:0]   t_mag,
   input  logic [svpwm_pkg::CSR_W-1:0]    modulation_gain,
   input  logic [svpwm_pkg::CSR_W-1:0]    half_period,
   input  logic [svpwm_pkg::CSR_W-1:0]    auto_reload,
   output logic [svpwm_pkg::CSR_W-1:0]    compare
);
   import svpwm_pkg::*;

   logic                       neg1_ff, neg1_in;
   logic [PROD1_W-1:0]         prod1_ff, prod1_in;
   logic                       neg2_ff, neg2_in;
   logic [SCALED_W-1:0]        scaled_ff, scaled_in;
   logic [PROD2_W-1:0]         prod2;
   logic signed [SUM_W-1:0]    sum;
   logic [CSR_W-1:0]           compare_ff, compare_in;

   // magnitude times gain
   assign neg1_in  = t_neg;
   assign prod1_in = PROD1_W'(t_mag) * PROD1_W'(modulation_gain);

   // times half period, truncate toward zero on the magnitude
   assign prod2     = PROD2_W'(prod1_ff) * PROD2_W'(half_period);
   assign neg2_in   = neg1_ff;
   assign scaled_in = prod2[PROD2_W-1:SHIFT];

   // restore sign, center on half period, clamp to zero and to reload
   always_comb begin
      if (neg2_ff) begin
         sum = $signed({2'b00, SCALED_W'(half_period)}) - $signed({2'b00, scaled_ff});
      end else begin
         sum = $signed({2'b00, SCALED_W'(half_period)}) + $signed({2'b00, scaled_ff});
      end
      if (sum < 0) begin
         compare_in = '0;
      end else if (sum > $signed({2'b00, SCALED_W'(auto_reload)})) begin
         compare_in = auto_reload;
      end else begin
         compare_in = sum[CSR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         neg1_ff  <= neg1_in;
         prod1_ff <= prod1_in;
      end
      if (adv[1]) begin
         neg2_ff   <= neg2_in;
         scaled_ff <= scaled_in;
      end
      if (adv[2]) begin
         compare_ff <= compare_in;
      end
   end

   assign compare = compare_ff;

endmodule

FILE: design/svpwm_sector_and_compare.sv
// channel   direction  payload
// req_chan  in         u_alpha, u_beta (signed q1.15)
// rsp_chan  out        sector, compare_a, compare_b, compare_c
// csr_*     in         write enable, register index, 16-bit write data
//
// six register stages; one item enters per cycle while the first stage can move
// the two multiplies of the compare scaling sit in separate stages, one per stage
// reset clears the stage valid bits and loads the register defaults
// each stage moves when it is empty or the stage after it moves, so a stall
// on rsp_chan backs up through the bubbles without loss or repeat
module svpwm_sector_and_compare (
   input  logic                             clock,
   input  logic                             reset,
   svpwm_req_if.sink                        req_chan,
   svpwm_rsp_if.source                      rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [svpwm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [svpwm_pkg::CSR_W-1:0]      csr_wr_data
);
   import svpwm_pkg::*;

   localparam int STAGES = 6;

   // configuration registers
   logic [CSR_W-1:0] gain_ff, half_ff, reload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         half_ff   <= HALF_RESET;
         reload_ff <= RELOAD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN:   gain_ff   <= csr_wr_data;
            CSR_HALF:   half_ff   <= csr_wr_data;
            CSR_RELOAD: reload_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // stage valid bits and advance chain
   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || rsp_chan.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = req_chan.valid;
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (adv[i]) vld_ff[i] <= vld_in[i];
         end
      end
   end

   assign req_chan.ready = adv[0];

   // stage 1: v1 and v2
   logic signed [31:0]          alpha_ext, beta_ext, v2_sum;
   logic signed [AXIS_W-1:0]    v1_s1_ff;
   logic signed [V2_W-1:0]      v2_s1_ff, v2_s1_in;

   assign alpha_ext = 32'(req_chan.data.u_alpha);
   assign beta_ext  = 32'(req_chan.data.u_beta);
   assign v2_sum    = (beta_ext <<< 14) + alpha_ext * SQRT3_HALF_Q15;
   assign v2_s1_in  = v2_sum[31:15];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         v1_s1_ff <= req_chan.data.u_beta;
         v2_s1_ff <= v2_s1_in;
      end
   end

   // stage 2: v3 and sector
   logic signed [VWIDE_W-1:0] v1_w, v2_w, v3_w;
   logic signed [VWIDE_W-1:0] v1_s2_ff, v2_s2_ff, v3_s2_ff;
   logic [SECTOR_W-1:0]       sec_base, sec_s2_in, sec_s2_ff;

   always_comb begin
      v1_w     = VWIDE_W'(v1_s1_ff);
      v2_w     = VWIDE_W'(v2_s1_ff);
      v3_w     = v2_w - v1_w;
      sec_base = 3'd3 - {2'b00, (v2_w > 0)} - {2'b00, (v3_w > 0)};
      sec_s2_in = (v1_w < 0) ? 3'd7 - sec_base : sec_base;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         v1_s2_ff  <= v1_w;
         v2_s2_ff  <= v2_w;
         v3_s2_ff  <= v3_w;
         sec_s2_ff <= sec_s2_in;
      end
   end

   // stage 3: phase times, saturate, split into sign and magnitude
   function automatic logic signed [TIME_W-1:0] sat_time(logic signed [VWIDE_W-1:0] t);
      if (t > T_MAX) return T_MAX[TIME_W-1:0];
      if (t < T_MIN) return T_MIN[TIME_W-1:0];
      return t[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] mag_of(logic signed [TIME_W-1:0] t);
      return t[TIME_W-1] ? TIME_W'(-t) : TIME_W'(t);
   endfunction

   logic signed [VWIDE_W-1:0] ta_w, tb_w, tc_w;
   logic signed [TIME_W-1:0]  ta_s, tb_s, tc_s;
   logic [2:0]                neg_s3_ff, neg_s3_in;
   logic [TIME_W-1:0]         mag_s3_ff [3];
   logic [TIME_W-1:0]         mag_s3_in [3];
   logic [SECTOR_W-1:0]       sec_s3_ff, sec_s4_ff, sec_s5_ff, sec_s6_ff;

   always_comb begin
      case (sec_s2_ff)
         3'd1, 3'd4: begin
            ta_w = v2_s2_ff;
            tb_w = v1_s2_ff - v3_s2_ff;
            tc_w = -v2_s2_ff;
         end
         3'd2, 3'd5: begin
            ta_w = v3_s2_ff + v2_s2_ff;
            tb_w = v1_s2_ff;
            tc_w = -v1_s2_ff;
         end
         3'd3, 3'd6: begin
            ta_w = v3_s2_ff;
            tb_w = -v3_s2_ff;
            tc_w = -(v1_s2_ff + v2_s2_ff);
         end
         // zero vector, not reached from a valid pair
         default: begin
            ta_w = '0;
            tb_w = '0;
            tc_w = '0;
         end
      endcase
      ta_s = sat_time(ta_w);
      tb_s = sat_time(tb_w);
      tc_s = sat_time(tc_w);
      neg_s3_in    = {tc_s[TIME_W-1], tb_s[TIME_W-1], ta_s[TIME_W-1]};
      mag_s3_in[0] = mag_of(ta_s);
      mag_s3_in[1] = mag_of(tb_s);
      mag_s3_in[2] = mag_of(tc_s);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         neg_s3_ff <= neg_s3_in;
         mag_s3_ff <= mag_s3_in;
         sec_s3_ff <= sec_s2_ff;
      end
      if (adv[3]) sec_s4_ff <= sec_s3_ff;
      if (adv[4]) sec_s5_ff <= sec_s4_ff;
      if (adv[5]) sec_s6_ff <= sec_s5_ff;
   end

   // stages 4 to 6: scaling and clamp, one lane per phase
   logic [CSR_W-1:0] compare [3];

   for (genvar p = 0; p < 3; p++) begin : g_lane
      svpwm_scale u_scale (
         .clock           (clock),
         .adv             (adv[5:3]),
         .t_neg           (neg_s3_ff[p]),
         .t_mag           (mag_s3_ff[p]),
         .modulation_gain (gain_ff),
         .half_period     (half_ff),
         .auto_reload     (reload_ff),
         .compare         (compare[p])
      );
   end

   // result transfer
   assign rsp_chan.valid          = vld_ff[STAGES-1];
   assign rsp_chan.data.sector    = sec_s6_ff;
   assign rsp_chan.data.compare_a = compare[0];
   assign rsp_chan.data.compare_b = compare[1];
   assign rsp_chan.data.compare_c = compare[2];

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import svpwm_pkg::*;

   // index past the end of the register list, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint HALF_Q15 = 16384;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 45;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   svpwm_req_if req_chan ();
   svpwm_rsp_if rsp_chan ();

   svpwm_sector_and_compare dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the block registers
   logic [CSR_W-1:0] gain_set = GAIN_RESET;
   logic [CSR_W-1:0] half_set = HALF_RESET;
   logic [CSR_W-1:0] reload_set = RELOAD_RESET;

   req_type vector_queue[$];
   rsp_type compare_queue[$];
   int queued_count = 0;
   int sent_count = 0;
   int error_count = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   int req_gap_max = 0;
   int rsp_stall_max = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
   end

   // scale one phase time into a clamped timer compare value
   function automatic logic [CSR_W-1:0] time_to_compare(longint t);
      longint mag, scaled, c;
      if (t > longint'(T_MAX)) t = longint'(T_MAX);
      else if (t < longint'(T_MIN)) t = longint'(T_MIN);
      mag = (t < 0) ? -t : t;
      scaled = (mag * longint'(gain_set) * longint'(half_set)) >>> SHIFT;
      if (t < 0) scaled = -scaled;
      c = scaled + longint'(half_set);
      if (c < 0) c = 0;
      if (c > longint'(reload_set)) c = longint'(reload_set);
      return c[CSR_W-1:0];
   endfunction

   // sector search and per-sector phase times for one voltage vector
   function automatic rsp_type calc_sector_compare(req_type v);
      longint v1, v2, v3, ta, tb, tc;
      int s;
      rsp_type r;
      v1 = longint'(v.u_beta);
      v2 = (longint'(v.u_beta) * HALF_Q15
            + longint'(v.u_alpha) * longint'(SQRT3_HALF_Q15)) >>> 15;
      v3 = v2 - v1;
      s = 3;
      if (v2 > 0) s--;
      if (v3 > 0) s--;
      if (v1 < 0) s = 7 - s;
      case (s)
         1, 4: begin
            ta = v2;
            tb = v1 - v3;
            tc = -v2;
         end
         2, 5: begin
            ta = v3 + v2;
            tb = v1;
            tc = -v1;
         end
         3, 6: begin
            ta = v3;
            tb = -v3;
            tc = -(v1 + v2);
         end
         default: begin
            ta = 0;
            tb = 0;
            tc = 0;
         end
      endcase
      r.sector = s[SECTOR_W-1:0];
      r.compare_a = time_to_compare(ta);
      r.compare_b = time_to_compare(tb);
      r.compare_c = time_to_compare(tc);
      return r;
   endfunction

   task automatic report_error(string msg);
      $display("%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(string field, int got, int want);
      if (got != want)
         report_error($sformatf("%s mismatch: got %0d expected %0d", field, got, want));
   endtask

   task automatic queue_vector(logic signed [AXIS_W-1:0] alpha,
                               logic signed [AXIS_W-1:0] beta);
      req_type v;
      v.u_alpha = alpha;
      v.u_beta = beta;
      vector_queue.push_back(v);
      queued_count++;
   endtask

   // register write, shadow follows at the edge that loads it
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_GAIN: gain_set = value;
         CSR_HALF: half_set = value;
         CSR_RELOAD: reload_set = value;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (sent_count != queued_count || compare_queue.size() != 0)
         @(posedge clock);
   endtask

   // axis value: mostly full range, with extremes and small magnitudes mixed in
   function automatic logic signed [AXIS_W-1:0] pick_axis();
      case ($urandom_range(3, 0))
         0: begin
            case ($urandom_range(4, 0))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return 16'sh0000;
               3: return 16'shffff;
               default: return 16'sh0001;
            endcase
         end
         1: return AXIS_W'($signed($urandom_range(512, 0)) - 256);
         default: return AXIS_W'($urandom);
      endcase
   endfunction

   // sender: one transfer in flight, random gap after each accepted vector
   always @(posedge clock) begin : req_drive
      logic next_valid;
      req_type next_data;
      int gap;
      next_valid = req_chan.valid;
      next_data = req_chan.data;
      gap = req_gap;
      if (reset) begin
         next_valid = 1'b0;
         gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            compare_queue.push_back(calc_sector_compare(req_chan.data));
            sent_count++;
            next_valid = 1'b0;
            gap = $urandom_range(req_gap_max, 0);
         end
         if (!next_valid) begin
            if (gap > 0) gap--;
            else if (vector_queue.size() > 0) begin
               next_valid = 1'b1;
               next_data = vector_queue.pop_front();
            end
         end
      end
      req_chan.valid <= next_valid;
      req_chan.data <= next_data;
      req_gap <= gap;
   end

   // receiver: compare each result transfer, then stall ready at random
   always @(posedge clock) begin : rsp_check
      logic next_ready;
      int stall;
      rsp_type want;
      next_ready = rsp_chan.ready;
      stall = rsp_stall;
      if (reset) begin
         next_ready = 1'b0;
         stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (compare_queue.size() == 0) begin
               report_error($sformatf("result with nothing expected, sector %0d",
                                      rsp_chan.data.sector));
            end else begin
               want = compare_queue.pop_front();
               check_field("sector", int'(rsp_chan.data.sector), int'(want.sector));
               check_field("compare_a", int'(rsp_chan.data.compare_a),
                           int'(want.compare_a));
               check_field("compare_b", int'(rsp_chan.data.compare_b),
                           int'(want.compare_b));
               check_field("compare_c", int'(rsp_chan.data.compare_c),
                           int'(want.compare_c));
            end
            stall = $urandom_range(rsp_stall_max, 0);
         end
         if (stall > 0) begin
            stall--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
      end
      rsp_chan.ready <= next_ready;
      rsp_stall <= stall;
   end

   // stimulus sequence
   initial begin : stimulus
      logic [CSR_W-1:0] gain, half, reload;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed vectors at reset settings, no idling on either side
      queue_vector(16'sh0000, 16'sh0000);
      queue_vector(16'sh7fff, 16'sh0000);
      queue_vector(16'sh8000, 16'sh0000);
      queue_vector(16'sh0000, 16'sh7fff);
      queue_vector(16'sh0000, 16'sh8000);
      queue_vector(16'sh7fff, 16'sh7fff);
      queue_vector(16'sh8000, 16'sh8000);
      queue_vector(16'sh7fff, 16'sh8000);
      queue_vector(16'sh8000, 16'sh7fff);
      queue_vector(16'sh0001, 16'sh0000);
      queue_vector(16'sh0000, 16'sh0001);
      queue_vector(16'shffff, 16'sh0000);
      queue_vector(16'sh0000, 16'shffff);
      queue_vector(16'shffff, 16'shffff);
      // points on the sector borders, v1, v2 or v3 exactly zero
      queue_vector(16'sd8192, 16'sd14189);
      queue_vector(-16'sd8192, -16'sd14189);
      queue_vector(-16'sd8192, 16'sd14189);
      queue_vector(16'sd8192, -16'sd14189);
      queue_vector(16'sd16384, 16'sd0);
      queue_vector(-16'sd16384, 16'sd0);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin gain = 16'hffff; half = 16'hffff; reload = 16'hffff; end
            1: begin gain = 16'h0000; half = 16'd1000; reload = 16'd2000; end
            2: begin gain = 16'hffff; half = 16'h0000; reload = 16'hffff; end
            // half period above reload
            3: begin gain = 16'd8192; half = 16'd40000; reload = 16'd30000; end
            4: begin gain = 16'd4096; half = 16'hffff; reload = 16'h0000; end
            5: begin gain = 16'h0000; half = 16'h0000; reload = 16'h0000; end
            default: begin
               gain = CSR_W'($urandom);
               half = CSR_W'($urandom);
               reload = CSR_W'($urandom);
            end
         endcase
         write_csr(CSR_GAIN, gain);
         write_csr(CSR_HALF, half);
         write_csr(CSR_RELOAD, reload);
         write_csr(CSR_SPARE, CSR_W'($urandom));

         case (phase % 4)
            0: begin req_gap_max = 15; rsp_stall_max = 15; end
            1: begin req_gap_max = 0; rsp_stall_max = 0; end
            2: begin req_gap_max = 15; rsp_stall_max = 0; end
            default: begin req_gap_max = 0; rsp_stall_max = 15; end
         endcase

         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_vector(pick_axis(), pick_axis());
         // hold the sender until the block has emptied
         wait_drained();
      end

      repeat (12) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
design/svpwm_pkg.sv
design/svpwm_req_if.sv
design/svpwm_rsp_if.sv
design/svpwm_scale.sv
design/svpwm_sector_and_compare.sv
bench/testbench.sv
